// File: sv/ftc_pkg.sv
// shared types and constants for the threaded code core
// no dependencies

package ftc_pkg;

  localparam int OPCODE_W   = 5;
  localparam int OPERAND_W  = 32;
  localparam int FAULT_W    = 3;
  localparam int IN_TDATA_W = ((OPCODE_W + OPERAND_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CALL        = 5'd0,
    OP_RETURN      = 5'd1,
    OP_LITERAL     = 5'd2,
    OP_INC         = 5'd3,
    OP_DEC         = 5'd4,
    OP_HALF        = 5'd5,
    OP_DOUBLE      = 5'd6,
    OP_ADD         = 5'd7,
    OP_DROP        = 5'd8,
    OP_DUP         = 5'd9,
    OP_SWAP        = 5'd10,
    OP_ROT         = 5'd11,
    OP_MAX         = 5'd12,
    OP_BRANCH      = 5'd13,
    OP_BRANCH_ZERO = 5'd14,
    OP_IS_ZERO     = 5'd15,
    OP_AND         = 5'd16,
    OP_GREATER     = 5'd17,
    OP_PRINT       = 5'd18,
    OP_NEWLINE     = 5'd19,
    OP_HALT        = 5'd20
  } op_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE       = 3'd0,
    FAULT_DATA_OVER  = 3'd1,
    FAULT_DATA_UNDER = 3'd2,
    FAULT_RET_OVER   = 3'd3,
    FAULT_RET_UNDER  = 3'd4,
    FAULT_BAD_OP     = 3'd5
  } fault_t;

endpackage

// File: sv/ftc_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies

module ftc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/forth_threaded_code_core.sv
// execution core of a direct-threaded forth machine
// depends on ftc_pkg and ftc_ram

// Usage
// The in_ channel carries one fetched instruction per transaction: opcode and
// its inline operand. For each one the out_ channel returns exactly one
// transaction: next fetch address, data stack top and depth, print and newline
// events, halt status and fault code.
// Each result is registered into the output register, or into the skid entry
// when the receiver stalls; one instruction can be taken each cycle while
// in_tready is high. The top three data stack cells and the top return
// address live in registers; deeper cells sit in two rams whose next entry
// below the top is always prefetched, with a forwarding register covering a
// push followed by a pop of the same entry.
// Output is a two-entry register/skid pair: in_tready stays high while the
// skid entry is empty and drops only when both entries are full.
// Synchronous active-low reset clears the address, both depths, the halt flag
// and the output channel; stack ram contents are not cleared.
// After halt every instruction is answered with the frozen state.

module forth_threaded_code_core
  import ftc_pkg::*;
#(
  parameter int CELL_WIDTH         = 32,
  parameter int ADDRESS_WIDTH      = 16,
  parameter int DATA_STACK_DEPTH   = 1024,
  parameter int RETURN_STACK_DEPTH = 1024,
  localparam int DDW      = $clog2(DATA_STACK_DEPTH + 1),
  localparam int OUT_BITS = ADDRESS_WIDTH + 2 * CELL_WIDTH + DDW + 3 + FAULT_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode, operand
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // next_address, top_value, stack_depth, print_valid, print_value,
  // newline_valid, halted, fault
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);

  // architectural state
  logic [ADDRESS_WIDTH-1:0] ia_r, ia_nxt;
  logic [DDW-1:0]           dep_r, dep_nxt;
  logic [CELL_WIDTH-1:0]    t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic [RDW-1:0]           rdep_r, rdep_nxt;
  logic [ADDRESS_WIDTH-1:0] rtop_r, rtop_nxt;
  logic                     stopped_r, stopped_nxt;

  // stack rams and forwarding
  logic                     ds_we;
  logic [DAW-1:0]           ds_waddr, ds_raddr;
  logic [CELL_WIDTH-1:0]    ds_rdata, ds_q;
  logic                     ds_fwd_r, ds_fwd_nxt;
  logic [CELL_WIDTH-1:0]    ds_fwd_data_r;
  logic                     rs_we;
  logic [RAW-1:0]           rs_waddr, rs_raddr;
  logic [ADDRESS_WIDTH-1:0] rs_rdata, rs_q;
  logic                     rs_fwd_r, rs_fwd_nxt;
  logic [ADDRESS_WIDTH-1:0] rs_fwd_data_r;

  // decode
  logic                     accept;
  logic [OPCODE_W-1:0]      op;
  logic signed [63:0]       opnd_ext;
  logic [CELL_WIDTH-1:0]    lit;
  logic [ADDRESS_WIDTH-1:0] target, ia1, ia2;
  logic [1:0]               need;
  logic                     push;
  fault_t                   fault;
  logic                     exec;
  logic                     pvalid, nl;
  logic [CELL_WIDTH-1:0]    pv;
  logic [OUT_BITS-1:0]      res_word;

  // output register and skid
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]      out_data_r, out_data_nxt;
  logic                     skid_valid_r, skid_valid_nxt;
  logic [OUT_BITS-1:0]      skid_data_r, skid_data_nxt;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  assign op       = in_tdata[OPCODE_W-1:0];
  assign opnd_ext = 64'(signed'(in_tdata[OPCODE_W +: OPERAND_W]));
  assign lit      = opnd_ext[CELL_WIDTH-1:0];
  assign target   = opnd_ext[ADDRESS_WIDTH-1:0];
  assign ia1      = ia_r + ADDRESS_WIDTH'(1);
  assign ia2      = ia_r + ADDRESS_WIDTH'(2);

  assign ds_q = ds_fwd_r ? ds_fwd_data_r : ds_rdata;
  assign rs_q = rs_fwd_r ? rs_fwd_data_r : rs_rdata;

  always_comb begin
    need = 2'd0;
    push = 1'b0;
    case (op)
      OP_LITERAL, OP_DUP: begin
        push = 1'b1;
        need = (op == OP_DUP) ? 2'd1 : 2'd0;
      end
      OP_INC, OP_DEC, OP_HALF, OP_DOUBLE, OP_DROP, OP_BRANCH_ZERO,
      OP_IS_ZERO, OP_PRINT: need = 2'd1;
      OP_ADD, OP_SWAP, OP_MAX, OP_AND, OP_GREATER: need = 2'd2;
      OP_ROT: need = 2'd3;
      default: need = 2'd0;
    endcase
  end

  always_comb begin
    fault = FAULT_NONE;
    if (!stopped_r) begin
      if (op > OP_HALT) begin
        fault = FAULT_BAD_OP;
      end else if (dep_r < DDW'(need)) begin
        fault = FAULT_DATA_UNDER;
      end else if (push && dep_r >= DDW'(DATA_STACK_DEPTH)) begin
        fault = FAULT_DATA_OVER;
      end else if (op == OP_CALL && rdep_r >= RDW'(RETURN_STACK_DEPTH)) begin
        fault = FAULT_RET_OVER;
      end else if (op == OP_RETURN && rdep_r == '0) begin
        fault = FAULT_RET_UNDER;
      end
    end
  end

  assign exec = accept && !stopped_r && fault == FAULT_NONE;

  always_comb begin
    ia_nxt      = ia_r;
    dep_nxt     = dep_r;
    t0_nxt      = t0_r;
    t1_nxt      = t1_r;
    t2_nxt      = t2_r;
    rdep_nxt    = rdep_r;
    rtop_nxt    = rtop_r;
    stopped_nxt = stopped_r;
    ds_we       = 1'b0;
    ds_waddr    = DAW'(dep_r - DDW'(3));
    rs_we       = 1'b0;
    rs_waddr    = RAW'(rdep_r - RDW'(1));
    pvalid      = 1'b0;
    pv          = '0;
    nl          = 1'b0;
    if (exec) begin
      ia_nxt = ia1;
      case (op)
        OP_CALL: begin
          rs_we    = rdep_r != '0;
          rtop_nxt = ia2;
          rdep_nxt = rdep_r + RDW'(1);
          ia_nxt   = target;
        end
        OP_RETURN: begin
          ia_nxt   = rtop_r;
          rtop_nxt = rs_q;
          rdep_nxt = rdep_r - RDW'(1);
        end
        OP_LITERAL, OP_DUP: begin
          ds_we   = dep_r >= DDW'(3);
          t0_nxt  = (op == OP_LITERAL) ? lit : t0_r;
          t1_nxt  = t0_r;
          t2_nxt  = t1_r;
          dep_nxt = dep_r + DDW'(1);
          if (op == OP_LITERAL) begin
            ia_nxt = ia2;
          end
        end
        OP_INC:     t0_nxt = t0_r + CELL_WIDTH'(1);
        OP_DEC:     t0_nxt = t0_r - CELL_WIDTH'(1);
        OP_HALF:    t0_nxt = CELL_WIDTH'($signed(t0_r) >>> 1);
        OP_DOUBLE:  t0_nxt = t0_r << 1;
        OP_IS_ZERO: t0_nxt = CELL_WIDTH'(t0_r == '0);
        OP_SWAP: begin
          t0_nxt = t1_r;
          t1_nxt = t0_r;
        end
        OP_ROT: begin
          t0_nxt = t2_r;
          t1_nxt = t0_r;
          t2_nxt = t1_r;
        end
        OP_ADD, OP_MAX, OP_AND, OP_GREATER, OP_DROP, OP_PRINT,
        OP_BRANCH_ZERO: begin
          t1_nxt  = t2_r;
          t2_nxt  = ds_q;
          dep_nxt = dep_r - DDW'(1);
          case (op)
            OP_ADD:     t0_nxt = t1_r + t0_r;
            OP_AND:     t0_nxt = t1_r & t0_r;
            OP_MAX:     t0_nxt = ($signed(t0_r) > $signed(t1_r)) ? t0_r : t1_r;
            OP_GREATER: t0_nxt = CELL_WIDTH'($signed(t1_r) > $signed(t0_r));
            default:    t0_nxt = t1_r;
          endcase
          if (op == OP_PRINT) begin
            pvalid = 1'b1;
            pv     = t0_r;
          end
          if (op == OP_BRANCH_ZERO) begin
            ia_nxt = (t0_r == '0) ? target : ia2;
          end
        end
        OP_BRANCH:  ia_nxt = target;
        OP_NEWLINE: nl = 1'b1;
        OP_HALT: begin
          stopped_nxt = 1'b1;
          ia_nxt      = ia_r;
        end
        default: ia_nxt = ia_r;
      endcase
    end
  end

  // prefetch the entry just below the register window
  assign ds_raddr   = DAW'(dep_nxt - DDW'(4));
  assign rs_raddr   = RAW'(rdep_nxt - RDW'(2));
  assign ds_fwd_nxt = ds_we && ds_waddr == ds_raddr;
  assign rs_fwd_nxt = rs_we && rs_waddr == rs_raddr;

  ftc_ram #(
    .WIDTH (CELL_WIDTH),
    .DEPTH (DATA_STACK_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (ds_we),
    .waddr (ds_waddr),
    .wdata (t2_r),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  ftc_ram #(
    .WIDTH (ADDRESS_WIDTH),
    .DEPTH (RETURN_STACK_DEPTH)
  ) u_return_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rtop_r),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  assign res_word = {fault, stopped_nxt, nl, pv, pvalid, dep_nxt,
                     (dep_nxt != '0) ? t0_nxt : CELL_WIDTH'(0), ia_nxt};

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res_word;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ia_r         <= '0;
      dep_r        <= '0;
      rdep_r       <= '0;
      stopped_r    <= 1'b0;
      ds_fwd_r     <= 1'b0;
      rs_fwd_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      ia_r         <= ia_nxt;
      dep_r        <= dep_nxt;
      rdep_r       <= rdep_nxt;
      stopped_r    <= stopped_nxt;
      ds_fwd_r     <= ds_fwd_nxt;
      rs_fwd_r     <= rs_fwd_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t0_r          <= t0_nxt;
    t1_r          <= t1_nxt;
    t2_r          <= t2_nxt;
    rtop_r        <= rtop_nxt;
    ds_fwd_data_r <= t2_r;
    rs_fwd_data_r <= rtop_r;
    out_data_r    <= out_data_nxt;
    skid_data_r   <= skid_data_nxt;
  end

endmodule

// File: verif/tb_forth_threaded_code_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the threaded code core: streams instructions, predicts
// every result from its own copy of the stacks and compares each output transaction
// depends on ftc_pkg and forth_threaded_code_core

module tb_forth_threaded_code_core
  import ftc_pkg::*;
();

  localparam int ADDR_W       = 16;
  localparam int CELL_W       = 32;
  localparam int DSTACK_DEPTH = 1024;
  localparam int RSTACK_DEPTH = 1024;
  localparam int DEPTH_W      = $clog2(DSTACK_DEPTH + 1);
  localparam int OUT_BITS     = ADDR_W + 2 * CELL_W + DEPTH_W + 3 + FAULT_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [OPCODE_W-1:0] OP_BAD_LOW  = 5'd21;
  localparam logic [OPCODE_W-1:0] OP_BAD_HIGH = 5'd31;

  typedef struct packed {
    logic [FAULT_W-1:0] fault;
    logic               halted;
    logic               newline_valid;
    logic [CELL_W-1:0]  print_value;
    logic               print_valid;
    logic [DEPTH_W-1:0] stack_depth;
    logic [CELL_W-1:0]  top_value;
    logic [ADDR_W-1:0]  next_address;
  } core_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  forth_threaded_code_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predicted machine state
  logic [ADDR_W-1:0] pc_addr = '0;
  logic [CELL_W-1:0] dstk [DSTACK_DEPTH];
  logic [ADDR_W-1:0] rstk [RSTACK_DEPTH];
  int                ddepth = 0;
  int                rdepth = 0;
  bit                halted_state = 1'b0;

  // stimulus bookkeeping
  logic [IN_TDATA_W-1:0] instr_queue [$];
  core_result_t          expected_results [$];
  int  queued = 0;
  int  accepted = 0;
  int  checked = 0;
  int  mismatches = 0;
  int  fault_seen [6];
  int  peak_ddepth = 0;
  int  peak_rdepth = 0;
  int  plan_dd = 0;
  int  plan_rd = 0;
  bit  plan_halted = 1'b0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;

  function automatic int operands_needed(logic [OPCODE_W-1:0] opc);
    case (opc)
      OP_INC, OP_DEC, OP_HALF, OP_DOUBLE, OP_DROP, OP_DUP, OP_BRANCH_ZERO, OP_IS_ZERO,
      OP_PRINT: return 1;
      OP_ADD, OP_SWAP, OP_MAX, OP_AND, OP_GREATER: return 2;
      OP_ROT: return 3;
      default: return 0;
    endcase
  endfunction

  function automatic int data_delta(logic [OPCODE_W-1:0] opc);
    case (opc)
      OP_LITERAL, OP_DUP: return 1;
      OP_ADD, OP_DROP, OP_MAX, OP_BRANCH_ZERO, OP_AND, OP_GREATER, OP_PRINT: return -1;
      default: return 0;
    endcase
  endfunction

  // underflow is checked before overflow
  function automatic fault_t instr_fault(logic [OPCODE_W-1:0] opc, int dd, int rd);
    if (opc > OP_HALT) return FAULT_BAD_OP;
    if (dd < operands_needed(opc)) return FAULT_DATA_UNDER;
    if (data_delta(opc) > 0 && dd >= DSTACK_DEPTH) return FAULT_DATA_OVER;
    if (opc == OP_CALL && rd >= RSTACK_DEPTH) return FAULT_RET_OVER;
    if (opc == OP_RETURN && rd == 0) return FAULT_RET_UNDER;
    return FAULT_NONE;
  endfunction

  function automatic core_result_t execute_instruction(logic [OPCODE_W-1:0] opc,
                                                       logic [CELL_W-1:0] opnd);
    core_result_t      r;
    fault_t            flt;
    logic [ADDR_W-1:0] nxt;
    logic [CELL_W-1:0] a;
    int                t;
    r = '0;
    flt = FAULT_NONE;
    if (!halted_state) begin
      flt = instr_fault(opc, ddepth, rdepth);
      if (flt == FAULT_NONE) begin
        t = ddepth - 1;
        nxt = pc_addr + 16'd1;
        case (op_t'(opc))
          OP_CALL: begin
            rstk[rdepth] = pc_addr + 16'd2;
            rdepth++;
            nxt = opnd[ADDR_W-1:0];
          end
          OP_RETURN: begin
            rdepth--;
            nxt = rstk[rdepth];
          end
          OP_LITERAL: begin
            dstk[ddepth] = opnd;
            ddepth++;
            nxt = pc_addr + 16'd2;
          end
          OP_INC:    dstk[t] = dstk[t] + 32'd1;
          OP_DEC:    dstk[t] = dstk[t] - 32'd1;
          OP_HALF:   dstk[t] = $signed(dstk[t]) >>> 1;
          OP_DOUBLE: dstk[t] = dstk[t] << 1;
          OP_ADD: begin
            dstk[t-1] = dstk[t-1] + dstk[t];
            ddepth--;
          end
          OP_DROP: ddepth--;
          OP_DUP: begin
            dstk[ddepth] = dstk[t];
            ddepth++;
          end
          OP_SWAP: begin
            a = dstk[t];
            dstk[t] = dstk[t-1];
            dstk[t-1] = a;
          end
          OP_ROT: begin
            a = dstk[t-2];
            dstk[t-2] = dstk[t-1];
            dstk[t-1] = dstk[t];
            dstk[t] = a;
          end
          OP_MAX: begin
            dstk[t-1] = ($signed(dstk[t]) > $signed(dstk[t-1])) ? dstk[t] : dstk[t-1];
            ddepth--;
          end
          OP_BRANCH: nxt = opnd[ADDR_W-1:0];
          OP_BRANCH_ZERO: begin
            nxt = (dstk[t] == '0) ? opnd[ADDR_W-1:0] : pc_addr + 16'd2;
            ddepth--;
          end
          OP_IS_ZERO: dstk[t] = (dstk[t] == '0) ? 32'd1 : 32'd0;
          OP_AND: begin
            dstk[t-1] = dstk[t-1] & dstk[t];
            ddepth--;
          end
          OP_GREATER: begin
            dstk[t-1] = ($signed(dstk[t-1]) > $signed(dstk[t])) ? 32'd1 : 32'd0;
            ddepth--;
          end
          OP_PRINT: begin
            r.print_valid = 1'b1;
            r.print_value = dstk[t];
            ddepth--;
          end
          OP_NEWLINE: r.newline_valid = 1'b1;
          OP_HALT: begin
            halted_state = 1'b1;
            nxt = pc_addr;
          end
          default: ;
        endcase
        pc_addr = nxt;
      end
    end
    r.next_address = pc_addr;
    r.top_value    = (ddepth > 0) ? dstk[ddepth-1] : '0;
    r.stack_depth  = DEPTH_W'(ddepth);
    r.halted       = halted_state;
    r.fault        = flt;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d: %s expected %0h got %0h", checked, what, want, got);
  endtask

  task automatic check_field(string what, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (instr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= instr_queue.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and scoreboard
  always @(posedge clk) begin : scoreboard
    core_result_t want;
    core_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        want = execute_instruction(in_tdata[OPCODE_W-1:0], in_tdata[OPCODE_W +: OPERAND_W]);
        expected_results.push_back(want);
        fault_seen[want.fault]++;
        if (ddepth > peak_ddepth) peak_ddepth = ddepth;
        if (rdepth > peak_rdepth) peak_rdepth = rdepth;
        accepted++;
      end
      if (out_tvalid && out_tready) begin
        got = core_result_t'(out_tdata[$bits(core_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected transaction, next_address", '0,
                        CELL_W'(got.next_address));
        end else begin
          want = expected_results.pop_front();
          check_field("next_address", CELL_W'(want.next_address),
                      CELL_W'(got.next_address));
          check_field("top_value", want.top_value, got.top_value);
          check_field("stack_depth", CELL_W'(want.stack_depth), CELL_W'(got.stack_depth));
          check_field("print_valid", CELL_W'(want.print_valid), CELL_W'(got.print_valid));
          check_field("print_value", want.print_value, got.print_value);
          check_field("newline_valid", CELL_W'(want.newline_valid),
                      CELL_W'(got.newline_valid));
          check_field("halted", CELL_W'(want.halted), CELL_W'(got.halted));
          check_field("fault", CELL_W'(want.fault), CELL_W'(got.fault));
        end
        checked++;
      end
    end
  end

  function automatic logic [CELL_W-1:0] random_cell();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // queues one instruction and tracks the stack depths it leads to
  task automatic queue_instr(logic [OPCODE_W-1:0] opc, logic [CELL_W-1:0] opnd);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[OPCODE_W-1:0] = opc;
    w[OPCODE_W +: OPERAND_W] = opnd;
    instr_queue.push_back(w);
    queued++;
    if (!plan_halted && instr_fault(opc, plan_dd, plan_rd) == FAULT_NONE) begin
      plan_dd += data_delta(opc);
      if (opc == OP_CALL) plan_rd++;
      else if (opc == OP_RETURN) plan_rd--;
      else if (opc == OP_HALT) plan_halted = 1'b1;
    end
  endtask

  // mostly legal instructions for the current depths, some noise; never halt
  task automatic queue_random(int n);
    logic [OPCODE_W-1:0] opc;
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        do opc = OPCODE_W'($urandom_range(31)); while (opc == OP_HALT);
      end else begin
        if ($urandom_range(99) < ((plan_dd < 16) ? 35 : 10))
          opc = $urandom_range(1) ? OP_LITERAL : OP_DUP;
        else
          opc = OPCODE_W'($urandom_range(19));
        while (instr_fault(opc, plan_dd, plan_rd) != FAULT_NONE)
          opc = OPCODE_W'($urandom_range(19));
      end
      queue_instr(opc, random_cell());
    end
  endtask

  task automatic wait_drained();
    while (accepted != queued || expected_results.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 51;
    queue_instr(OP_DROP, '0);
    queue_instr(OP_RETURN, '0);
    queue_instr(OP_BAD_LOW, 32'h1234_5678);
    queue_instr(OP_BAD_HIGH, 32'hFFFF_FFFF);
    queue_instr(OP_LITERAL, 32'h7FFF_FFFF);
    queue_instr(OP_INC, '0);
    queue_instr(OP_DUP, '0);
    queue_instr(OP_DEC, '0);
    queue_instr(OP_SWAP, '0);
    queue_instr(OP_HALF, '0);
    queue_instr(OP_DOUBLE, '0);
    queue_instr(OP_LITERAL, 32'hFFFF_FFFF);
    queue_instr(OP_ROT, '0);
    queue_instr(OP_MAX, '0);
    queue_instr(OP_GREATER, '0);
    queue_instr(OP_IS_ZERO, '0);
    queue_instr(OP_LITERAL, 32'd3);
    queue_instr(OP_AND, '0);
    queue_instr(OP_LITERAL, 32'hFFFF_FFFF);
    queue_instr(OP_ADD, '0);
    queue_instr(OP_BRANCH_ZERO, 32'h0000_FFFF);
    queue_instr(OP_LITERAL, 32'd5);
    queue_instr(OP_BRANCH_ZERO, 32'h0000_1234);
    queue_instr(OP_CALL, 32'hFFFF_FFFE);
    queue_instr(OP_RETURN, '0);
    queue_instr(OP_LITERAL, 32'h8000_0000);
    queue_instr(OP_PRINT, '0);
    queue_instr(OP_NEWLINE, '0);
    queue_instr(OP_BRANCH, 32'h5A5A_ABCD);
    queue_random(150);
    wait_drained();

    // nested calls, then random traffic
    send_idle_pct = 51;
    recv_idle_pct = 31;
    repeat (40) queue_instr(OP_CALL, $urandom);
    queue_random(120);
    wait_drained();

    // data stack filled to the limit under backpressure, then halt
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (plan_dd < DSTACK_DEPTH)
      queue_instr($urandom_range(1) ? OP_LITERAL : OP_DUP, $urandom);
    queue_instr(OP_LITERAL, 32'h8000_0000);
    queue_instr(OP_DUP, '0);
    queue_random(30);
    queue_instr(OP_HALT, '0);
    queue_instr(OP_LITERAL, 32'h0000_0042);
    queue_instr(OP_DROP, '0);
    queue_instr(OP_BAD_HIGH, '0);
    queue_instr(OP_HALT, '0);
    hold_req = 1'b1;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d instructions and %0d results, peak depths data %0d return %0d",
             accepted, checked, peak_ddepth, peak_rdepth);
    $display("faults none %0d data over %0d data under %0d ret over %0d ret under %0d bad %0d",
             fault_seen[0], fault_seen[1], fault_seen[2], fault_seen[3], fault_seen[4],
             fault_seen[5]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
